// File: rtl/nvqp_pkg.sv
// Shared types and constants for the NVMe queue pair engine.
`default_nettype none

package nvqp_pkg;

   localparam int SQ_DEPTH = 64;
   localparam int CQ_DEPTH = 32;
   localparam int SQ_IDX_W = $clog2(SQ_DEPTH);
   localparam int CQ_IDX_W = $clog2(CQ_DEPTH);
   localparam int SQ_CNT_W = SQ_IDX_W + 1;
   localparam int CQ_CNT_W = CQ_IDX_W + 1;

   localparam int STATUS_CODE_W = 11;
   localparam int REQ_DATA_W = 104;
   localparam int RSP_DATA_W = 192;

   localparam logic [31:0] DB_BASE     = 32'h0000_1000;
   localparam logic [31:0] DWORD0_KEEP = 32'hFFFF_0000;

   typedef enum logic [1:0] {
      REQ_SUBMIT    = 2'd0,
      REQ_CPL_WRITE = 2'd1,
      REQ_PROCESS   = 2'd2,
      REQ_STAT      = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      RSP_SUBMITTED  = 3'd0,
      RSP_REJECTED   = 3'd1,
      RSP_COMPLETION = 3'd2,
      RSP_DONE       = 3'd3,
      RSP_STAT       = 3'd4,
      RSP_WRITE_ACK  = 3'd5
   } rsp_kind_type;

   typedef enum logic [1:0] {
      STAT_SUBMIT   = 2'd0,
      STAT_COMPLETE = 2'd1,
      STAT_ERROR    = 2'd2
   } stat_sel_type;

   typedef enum logic [1:0] {
      CSR_SQ_SIZE   = 2'd0,
      CSR_CQ_SIZE   = 2'd1,
      CSR_QUEUE_ID  = 2'd2,
      CSR_DB_STRIDE = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK_RD,
      ST_WALK_CHK,
      ST_WALK_CTX,
      ST_DONE
   } nvqp_state_type;

   // request payload, last field in the lowest bits
   typedef struct packed {
      logic [1:0]          stat_select;
      logic [15:0]         max_completions;
      logic [15:0]         cpl_status;
      logic [15:0]         cpl_cid;
      logic [CQ_IDX_W-1:0] cq_slot;
      logic [15:0]         ctx_tag;
      logic [31:0]         cmd_dword0;
   } req_data_type;

   // response payload, last field in the lowest bits
   typedef struct packed {
      logic [63:0]              count;
      logic [15:0]              doorbell_value;
      logic [31:0]              doorbell_addr;
      logic                     doorbell_valid;
      logic                     is_error;
      logic [STATUS_CODE_W-1:0] status_code;
      logic [15:0]              ctx_out;
      logic [31:0]              sq_dword0;
      logic [15:0]              command_id;
   } rsp_data_type;

   typedef struct packed {
      logic [15:0] cid;
      logic [15:0] status;
   } cpl_entry_type;

   typedef struct packed {
      logic                en;
      logic [CQ_IDX_W-1:0] slot;
      cpl_entry_type       entry;
   } cpl_wr_type;

   typedef struct packed {
      logic                en;
      logic [CQ_IDX_W-1:0] addr;
   } cpl_rd_type;

endpackage

`default_nettype wire

// File: rtl/nvqp_cpl_store.sv
// Completion queue store: one write port, one registered read port, per-entry valid bits.
`default_nettype none

module nvqp_cpl_store (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire nvqp_pkg::cpl_wr_type   wr,
   input  wire nvqp_pkg::cpl_rd_type   rd,
   output nvqp_pkg::cpl_entry_type     rd_entry
);
   import nvqp_pkg::*;

   cpl_entry_type       store_mem [CQ_DEPTH];
   cpl_entry_type       rd_data_ff;
   logic                rd_valid_ff;
   logic                rd_valid_in;
   logic [CQ_DEPTH-1:0] valid_ff;
   logic [CQ_DEPTH-1:0] valid_in;

   // never-written entries read as the cleared value
   always_comb begin
      valid_in = valid_ff;
      if (wr.en) begin
         valid_in[wr.slot] = 1'b1;
      end
      rd_valid_in = rd.en ? valid_ff[rd.addr] : rd_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         store_mem[wr.slot] <= wr.entry;
      end
      if (rd.en) begin
         rd_data_ff <= store_mem[rd.addr];
      end
   end

   assign rd_entry = rd_valid_ff ? rd_data_ff : '0;

endmodule

`default_nettype wire

// File: rtl/nvme_queue_pair_engine.sv
// Top level of the NVMe queue pair engine: request decode, completion walk, response register.
`default_nettype none

// Host side of one NVMe submission/completion queue pair. A submit request
// (req_tuser = 0) stamps the SQ tail into the low half of command dword 0 as
// the command id, keeps the context tag under that id, advances the tail and
// returns one response with the SQ doorbell write; when outstanding commands
// reach the queue size minus one it is rejected instead. A completion write
// (1) stores a device entry in the CQ store, a process request (2) walks that
// store from the head, returning one response per entry whose phase matches
// and then a closing response with the count and the CQ doorbell write, and a
// statistic request (3) returns one 64-bit total. The last response of every
// request carries tlast. Submit, completion write and statistic requests can
// follow back to back while responses are taken. A process request steps
// through a CQ store read, a context store read and a response load for each
// delivered entry, as the two memory reads depend on each other; a stalled
// response port adds its wait. Both stores clear at reset through per-entry
// valid bits, so there is no clearing pass. The user must write registers on
// the csr_ port only while no request is in flight; the block has no check.

module nvme_queue_pair_engine (
   input  wire logic         clock,
   input  wire logic         reset,
   // request channel
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // tdata: cmd_dword0, ctx_tag, cq_slot, cpl_cid, cpl_status,
   //        max_completions, stat_select (lowest bits first), zero pad
   input  wire logic [103:0] req_tdata,
   // tuser: req_type
   input  wire logic [1:0]   req_tuser,
   // response channel
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // tdata: command_id, sq_dword0, ctx_out, status_code, is_error,
   //        doorbell_valid, doorbell_addr, doorbell_value, count, zero pad
   output logic [191:0]      rsp_tdata,
   // tuser: kind
   output logic [2:0]        rsp_tuser,
   output logic              rsp_tlast,
   // register write port
   input  wire logic         csr_we,
   input  wire logic [1:0]   csr_index,
   input  wire logic [16:0]  csr_wdata
);
   import nvqp_pkg::*;

   // effective queue sizes: log2 of zero counts as one, clamped to the store
   function automatic logic [SQ_CNT_W-1:0] sq_size(input logic [2:0] lg);
      logic [2:0] l;
      l = (lg == 3'd0) ? 3'd1 : lg;
      if (32'(l) >= SQ_IDX_W) sq_size = SQ_CNT_W'(SQ_DEPTH);
      else sq_size = SQ_CNT_W'(1) << l;
   endfunction

   function automatic logic [CQ_CNT_W-1:0] cq_size(input logic [2:0] lg);
      logic [2:0] l;
      l = (lg == 3'd0) ? 3'd1 : lg;
      if (32'(l) >= CQ_IDX_W) cq_size = CQ_CNT_W'(CQ_DEPTH);
      else cq_size = CQ_CNT_W'(1) << l;
   endfunction

   // doorbell offset: base + (2*qid + which) * stride, modulo 2^32
   function automatic logic [31:0] db_addr(input logic [15:0] qid, input logic which,
                                           input logic [16:0] stride);
      logic [33:0] prod;
      prod = {qid, which} * stride;
      db_addr = DB_BASE + prod[31:0];
   endfunction

   // configuration
   logic [2:0]  sq_log2_ff, sq_log2_in;
   logic [2:0]  cq_log2_ff, cq_log2_in;
   logic [15:0] queue_id_ff, queue_id_in;
   logic [16:0] db_stride_ff, db_stride_in;

   // queue state
   nvqp_state_type      state_ff, state_in;
   logic [SQ_IDX_W-1:0] sq_tail_ff, sq_tail_in;
   logic [SQ_CNT_W-1:0] outstanding_ff, outstanding_in;
   logic [CQ_IDX_W-1:0] cq_head_ff, cq_head_in;
   logic                cq_phase_ff, cq_phase_in;
   logic [63:0]         submit_total_ff, submit_total_in;
   logic [63:0]         complete_total_ff, complete_total_in;
   logic [63:0]         error_total_ff, error_total_in;
   logic [CQ_CNT_W-1:0] lim_ff, lim_in;
   logic [CQ_CNT_W-1:0] walk_n_ff, walk_n_in;

   // context store
   logic [15:0]         ctx_mem [SQ_DEPTH];
   logic [SQ_DEPTH-1:0] ctx_valid_ff, ctx_valid_in;
   logic [15:0]         ctx_rd_ff;
   logic                ctx_rd_valid_ff;
   logic                ctx_wr_en;
   logic                ctx_rd_en;
   logic                ctx_clear;
   logic [SQ_IDX_W-1:0] ctx_rd_addr;

   // completion store
   cpl_wr_type    cpl_wr;
   cpl_rd_type    cpl_rd;
   cpl_entry_type cpl_entry;

   // response register
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_kind_type rsp_kind_ff, rsp_kind_in;
   rsp_data_type rsp_data_ff, rsp_data_in;
   logic         rsp_last_ff, rsp_last_in;
   logic         rsp_load;

   // request decode helpers
   req_data_type        req;
   logic                req_fire;
   logic                out_free;
   logic [SQ_CNT_W-1:0] sqs;
   logic [CQ_CNT_W-1:0] cqs;
   logic                sq_full;
   logic [SQ_CNT_W-1:0] tail_inc;
   logic [CQ_CNT_W-1:0] head_inc;
   logic                cid_in_range;
   logic [15:0]         ctx_value;
   logic [STATUS_CODE_W-1:0] status_code;

   assign req       = req_data_type'(req_tdata[$bits(req_data_type)-1:0]);
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign req_fire  = req_tvalid && req_tready;

   assign sqs      = sq_size(sq_log2_ff);
   assign cqs      = cq_size(cq_log2_ff);
   assign sq_full  = SQ_CNT_W'(outstanding_ff + 1'b1) >= sqs;
   assign tail_inc = SQ_CNT_W'(sq_tail_ff) + 1'b1;
   assign head_inc = CQ_CNT_W'(cq_head_ff) + 1'b1;

   assign cid_in_range = 32'(cpl_entry.cid) < SQ_DEPTH;
   assign ctx_rd_addr  = cpl_entry.cid[SQ_IDX_W-1:0];
   assign ctx_value    = (cid_in_range && ctx_rd_valid_ff) ? ctx_rd_ff : 16'd0;
   assign status_code  = cpl_entry.status[STATUS_CODE_W:1];

   nvqp_cpl_store u_cpl_store (
      .clock    (clock),
      .reset    (reset),
      .wr       (cpl_wr),
      .rd       (cpl_rd),
      .rd_entry (cpl_entry)
   );

   // next state and response build
   always_comb begin
      state_in          = state_ff;
      sq_log2_in        = sq_log2_ff;
      cq_log2_in        = cq_log2_ff;
      queue_id_in       = queue_id_ff;
      db_stride_in      = db_stride_ff;
      sq_tail_in        = sq_tail_ff;
      outstanding_in    = outstanding_ff;
      cq_head_in        = cq_head_ff;
      cq_phase_in       = cq_phase_ff;
      submit_total_in   = submit_total_ff;
      complete_total_in = complete_total_ff;
      error_total_in    = error_total_ff;
      lim_in            = lim_ff;
      walk_n_in         = walk_n_ff;
      ctx_wr_en         = 1'b0;
      ctx_rd_en         = 1'b0;
      ctx_clear         = 1'b0;
      cpl_wr            = '0;
      cpl_rd            = '0;
      rsp_load          = 1'b0;
      rsp_kind_in       = rsp_kind_ff;
      rsp_data_in       = '0;
      rsp_last_in       = 1'b0;

      if (csr_we) begin
         case (csr_index)
            CSR_SQ_SIZE:   sq_log2_in   = csr_wdata[2:0];
            CSR_CQ_SIZE:   cq_log2_in   = csr_wdata[2:0];
            CSR_QUEUE_ID:  queue_id_in  = csr_wdata[15:0];
            CSR_DB_STRIDE: db_stride_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_tuser)
                  REQ_SUBMIT: begin
                     rsp_load    = 1'b1;
                     rsp_last_in = 1'b1;
                     if (sq_full) begin
                        rsp_kind_in = RSP_REJECTED;
                     end else begin
                        ctx_wr_en       = 1'b1;
                        sq_tail_in      = (tail_inc >= sqs) ? '0 : tail_inc[SQ_IDX_W-1:0];
                        outstanding_in  = outstanding_ff + 1'b1;
                        submit_total_in = submit_total_ff + 64'd1;
                        rsp_kind_in     = RSP_SUBMITTED;
                        rsp_data_in.command_id     = 16'(sq_tail_ff);
                        rsp_data_in.sq_dword0      = (req.cmd_dword0 & DWORD0_KEEP)
                                                     | 32'(sq_tail_ff);
                        rsp_data_in.doorbell_valid = 1'b1;
                        rsp_data_in.doorbell_addr  = db_addr(queue_id_ff, 1'b0,
                                                             db_stride_ff);
                        rsp_data_in.doorbell_value = 16'(sq_tail_in);
                     end
                  end
                  REQ_CPL_WRITE: begin
                     cpl_wr.en           = 1'b1;
                     cpl_wr.slot         = req.cq_slot;
                     cpl_wr.entry.cid    = req.cpl_cid;
                     cpl_wr.entry.status = req.cpl_status;
                     rsp_load            = 1'b1;
                     rsp_last_in         = 1'b1;
                     rsp_kind_in         = RSP_WRITE_ACK;
                  end
                  REQ_PROCESS: begin
                     if (req.max_completions == 16'd0 || req.max_completions > 16'(cqs)) begin
                        lim_in = cqs;
                     end else begin
                        lim_in = req.max_completions[CQ_CNT_W-1:0];
                     end
                     walk_n_in = '0;
                     state_in  = ST_WALK_RD;
                  end
                  REQ_STAT: begin
                     rsp_load    = 1'b1;
                     rsp_last_in = 1'b1;
                     rsp_kind_in = RSP_STAT;
                     case (req.stat_select)
                        STAT_SUBMIT:   rsp_data_in.count = submit_total_ff;
                        STAT_COMPLETE: rsp_data_in.count = complete_total_ff;
                        STAT_ERROR:    rsp_data_in.count = error_total_ff;
                        default:       rsp_data_in.count = 64'd0;
                     endcase
                  end
                  default: ;
               endcase
            end
         end

         // stop on the limit, otherwise fetch the head entry
         ST_WALK_RD: begin
            if (walk_n_ff >= lim_ff) begin
               state_in = ST_DONE;
            end else begin
               cpl_rd.en   = 1'b1;
               cpl_rd.addr = cq_head_ff;
               state_in    = ST_WALK_CHK;
            end
         end

         // phase mismatch ends the walk; else fetch the stored context
         ST_WALK_CHK: begin
            if (cpl_entry.status[0] != cq_phase_ff) begin
               state_in = ST_DONE;
            end else begin
               ctx_rd_en = 1'b1;
               state_in  = ST_WALK_CTX;
            end
         end

         ST_WALK_CTX: begin
            if (out_free) begin
               rsp_load    = 1'b1;
               rsp_kind_in = RSP_COMPLETION;
               rsp_data_in.command_id  = cpl_entry.cid;
               rsp_data_in.ctx_out     = ctx_value;
               rsp_data_in.status_code = status_code;
               rsp_data_in.is_error    = status_code != '0;
               ctx_clear         = cid_in_range;
               complete_total_in = complete_total_ff + 64'd1;
               if (outstanding_ff != '0) begin
                  outstanding_in = outstanding_ff - 1'b1;
               end
               if (status_code != '0) begin
                  error_total_in = error_total_ff + 64'd1;
               end
               if (head_inc >= cqs) begin
                  cq_head_in  = '0;
                  cq_phase_in = !cq_phase_ff;
               end else begin
                  cq_head_in = head_inc[CQ_IDX_W-1:0];
               end
               walk_n_in = walk_n_ff + 1'b1;
               state_in  = ST_WALK_RD;
            end
         end

         ST_DONE: begin
            if (out_free) begin
               rsp_load          = 1'b1;
               rsp_last_in       = 1'b1;
               rsp_kind_in       = RSP_DONE;
               rsp_data_in.count = 64'(walk_n_ff);
               if (walk_n_ff != '0) begin
                  rsp_data_in.doorbell_valid = 1'b1;
                  rsp_data_in.doorbell_addr  = db_addr(queue_id_ff, 1'b1, db_stride_ff);
                  rsp_data_in.doorbell_value = 16'(cq_head_ff);
               end
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase

      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_tready);
   end

   // context valid bits: set on submit, cleared on delivery
   always_comb begin
      ctx_valid_in = ctx_valid_ff;
      if (ctx_wr_en) begin
         ctx_valid_in[sq_tail_ff] = 1'b1;
      end
      if (ctx_clear) begin
         ctx_valid_in[ctx_rd_addr] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         sq_log2_ff        <= 3'd6;
         cq_log2_ff        <= 3'd5;
         queue_id_ff       <= 16'd0;
         db_stride_ff      <= 17'd4;
         sq_tail_ff        <= '0;
         outstanding_ff    <= '0;
         cq_head_ff        <= '0;
         cq_phase_ff       <= 1'b1;
         submit_total_ff   <= 64'd0;
         complete_total_ff <= 64'd0;
         error_total_ff    <= 64'd0;
         lim_ff            <= '0;
         walk_n_ff         <= '0;
         ctx_valid_ff      <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         sq_log2_ff        <= sq_log2_in;
         cq_log2_ff        <= cq_log2_in;
         queue_id_ff       <= queue_id_in;
         db_stride_ff      <= db_stride_in;
         sq_tail_ff        <= sq_tail_in;
         outstanding_ff    <= outstanding_in;
         cq_head_ff        <= cq_head_in;
         cq_phase_ff       <= cq_phase_in;
         submit_total_ff   <= submit_total_in;
         complete_total_ff <= complete_total_in;
         error_total_ff    <= error_total_in;
         lim_ff            <= lim_in;
         walk_n_ff         <= walk_n_in;
         ctx_valid_ff      <= ctx_valid_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_kind_ff <= rsp_kind_in;
         rsp_data_ff <= rsp_data_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   // context store
   always_ff @(posedge clock) begin
      if (ctx_wr_en) begin
         ctx_mem[sq_tail_ff] <= req.ctx_tag;
      end
      if (ctx_rd_en) begin
         ctx_rd_ff       <= ctx_mem[ctx_rd_addr];
         ctx_rd_valid_ff <= ctx_valid_ff[ctx_rd_addr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_data_ff);
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   // an accepted submission into a non-full queue adds one outstanding command
   a_submit_count: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tuser == REQ_SUBMIT && !sq_full)
      |=> outstanding_ff == SQ_CNT_W'($past(outstanding_ff) + 1'b1))
      else $error("outstanding count did not advance on submission");

   // the walk never delivers more entries than its limit
   a_walk_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> walk_n_ff <= lim_ff)
      else $error("completion walk ran past its limit");

   // the expected phase only flips as the head wraps to slot zero
   a_phase_wrap: assert property (@(posedge clock) disable iff (reset)
      !$stable(cq_phase_ff) |-> cq_head_ff == '0)
      else $error("phase flipped without head wrap");

   // closing response rings the CQ doorbell exactly when entries were delivered
   a_done_doorbell: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == RSP_DONE)
      |-> rsp_data_ff.doorbell_valid == (rsp_data_ff.count != 64'd0))
      else $error("CQ doorbell does not match completion count");

endmodule

`default_nettype wire

// File: test/tb_top.sv
// Self-checking testbench for the NVMe queue pair engine: directed table, then random queue traffic.
`timescale 1ns / 1ps

// Requests are driven with nonblocking assignments at the rising edge. Every
// accepted request is run through the testbench's own copy of the queue pair
// (SQ tail, CQ head and phase, context and completion stores, totals), which
// appends the responses it should cause to qp_rsp_due. The response monitor
// compares each accepted response, field by field, with the oldest entry there.
//
// Stimulus:
//  - a short directed table: reset values, extremes of dword 0 and tag, error
//    codes, ids beyond the context store, the full queue, walk limits and
//    wrap, unknown statistic selector, then the smallest queue sizes with the
//    largest queue id and stride;
//  - random phases, each with its own register setting. Most traffic mimics a
//    well-behaved device: submit a few commands, write completions for them
//    into consecutive CQ slots with the current phase, then process. The rest
//    is noise with every field random.
// Registers are only written once every expected response has arrived.

module tb_top;
   import nvqp_pkg::*;

   localparam int N_PHASES      = 8;
   localparam int PHASE_ITEMS   = 60;
   localparam int WATCHDOG_MAX  = 2000;
   localparam logic [1:0] STAT_UNKNOWN = 2'd3;

   // one expected response
   typedef struct packed {
      rsp_kind_type kind;
      logic         last;
      rsp_data_type data;
   } qp_rsp_type;

   // one row of the directed table; exp_* only where has_exp is set
   typedef struct packed {
      logic         cfg_before;
      req_kind_type kind;
      logic [31:0]  dword0;
      logic [15:0]  tag;
      logic [4:0]   slot;
      logic [15:0]  cid;
      logic [15:0]  status;
      logic [15:0]  limit;
      logic [1:0]   sel;
      logic         has_exp;
      rsp_kind_type exp_kind;
      logic [63:0]  exp_count;
   } dir_row_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [103:0] req_tdata;
   logic [1:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [191:0] rsp_tdata;
   logic [2:0]   rsp_tuser;
   logic         rsp_tlast;
   logic         csr_we;
   logic [1:0]   csr_index;
   logic [16:0]  csr_wdata;

   nvme_queue_pair_engine dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // Our copy of the queue pair: registers and state, reset values
   // ---------------------------------------------------------------
   logic [2:0]  cfg_sq_lg  = 3'd6;
   logic [2:0]  cfg_cq_lg  = 3'd5;
   logic [15:0] cfg_qid    = 16'd0;
   logic [16:0] cfg_stride = 17'd4;

   logic [5:0]  sq_tail     = '0;
   logic [4:0]  cq_head     = '0;
   logic        cq_phase    = 1'b1;
   logic [6:0]  outstanding = '0;
   logic [15:0] ctx_mem        [SQ_DEPTH];
   logic [15:0] cpl_cid_mem    [CQ_DEPTH];
   logic [15:0] cpl_status_mem [CQ_DEPTH];
   logic [63:0] submit_total   = '0;
   logic [63:0] complete_total = '0;
   logic [63:0] error_total    = '0;

   qp_rsp_type  qp_rsp_due[$];   // responses still to arrive, oldest first
   qp_rsp_type  final_rsp;       // closing response of the latest request
   logic        submit_ok;
   logic [15:0] submit_cid;
   int          walk_n;
   logic        walk_gap;        // walk ended on a phase mismatch

   // device-side view used to build well-formed completion traffic
   logic [4:0]  dev_slot;
   logic        dev_phase;
   int          dev_backlog;
   logic [15:0] open_ids[$];

   int          errors_seen = 0;
   int          sent_count  = 0;
   int          gap_pct     = 20;
   int          stall_pct   = 20;
   int          stall_left  = 0;
   logic        calm        = 1'b0;
   int          idle_cycles = 0;

   initial begin
      foreach (ctx_mem[i]) ctx_mem[i] = '0;
      foreach (cpl_cid_mem[i]) begin
         cpl_cid_mem[i]    = '0;
         cpl_status_mem[i] = '0;
      end
   end

   // entries in use: 2^lg, lg 0 counts as 1, clamped to the store depth
   function automatic int queue_len(logic [2:0] lg, int depth);
      int s;
      s = 1 << ((lg == 3'd0) ? 1 : int'(lg));
      return (s > depth) ? depth : s;
   endfunction

   // which = 0 for the SQ tail doorbell, 1 for the CQ head doorbell
   function automatic logic [31:0] doorbell_at(int which);
      logic [63:0] idx;
      idx = 64'd2 * 64'(cfg_qid) + 64'(which);
      return 32'(64'(DB_BASE) + idx * 64'(cfg_stride));
   endfunction

   // work out the responses one accepted request causes
   task automatic apply_request(input req_kind_type kind, input req_data_type d);
      qp_rsp_type  r;
      int          sqs;
      int          cqs;
      int          lim;
      logic [4:0]  h;
      logic [15:0] st;
      logic [15:0] cid;
      logic [10:0] sc;
      logic [15:0] ctx;
      r      = '0;
      r.last = 1'b1;
      case (kind)
         REQ_SUBMIT: begin
            sqs       = queue_len(cfg_sq_lg, SQ_DEPTH);
            submit_ok = 1'b0;
            if (int'(outstanding) + 1 >= sqs) begin
               r.kind = RSP_REJECTED;
            end else begin
               ctx_mem[sq_tail]    = d.ctx_tag;
               submit_ok           = 1'b1;
               submit_cid          = 16'(sq_tail);
               r.kind              = RSP_SUBMITTED;
               r.data.command_id   = 16'(sq_tail);
               r.data.sq_dword0    = (d.cmd_dword0 & DWORD0_KEEP) | 32'(sq_tail);
               sq_tail             = (int'(sq_tail) + 1 >= sqs) ? '0 : sq_tail + 6'd1;
               outstanding         = outstanding + 7'd1;
               submit_total        = submit_total + 64'd1;
               r.data.doorbell_valid = 1'b1;
               r.data.doorbell_addr  = doorbell_at(0);
               r.data.doorbell_value = 16'(sq_tail);
            end
         end
         REQ_CPL_WRITE: begin
            cpl_cid_mem[d.cq_slot]    = d.cpl_cid;
            cpl_status_mem[d.cq_slot] = d.cpl_status;
            r.kind = RSP_WRITE_ACK;
         end
         REQ_PROCESS: begin
            cqs      = queue_len(cfg_cq_lg, CQ_DEPTH);
            lim      = int'(d.max_completions);
            if (lim == 0 || lim > cqs) lim = cqs;
            walk_n   = 0;
            walk_gap = 1'b0;
            while (walk_n < lim && !walk_gap) begin
               h   = cq_head;
               st  = cpl_status_mem[h];
               cid = cpl_cid_mem[h];
               sc  = st[11:1];
               if (st[0] != cq_phase) begin
                  walk_gap = 1'b1;
               end else begin
                  ctx = '0;
                  // ids past the context store deliver 0 and clear nothing
                  if (int'(cid) < SQ_DEPTH) begin
                     ctx = ctx_mem[cid[5:0]];
                     ctx_mem[cid[5:0]] = '0;
                  end
                  complete_total = complete_total + 64'd1;
                  if (outstanding != 0) outstanding = outstanding - 7'd1;
                  if (sc != 0) error_total = error_total + 64'd1;
                  r                  = '0;
                  r.kind             = RSP_COMPLETION;
                  r.data.command_id  = cid;
                  r.data.ctx_out     = ctx;
                  r.data.status_code = sc;
                  r.data.is_error    = (sc != 0);
                  qp_rsp_due.push_back(r);
                  cq_head = (int'(h) + 1 >= cqs) ? '0 : h + 5'd1;
                  if (cq_head == 0) cq_phase = ~cq_phase;
                  walk_n++;
               end
            end
            r            = '0;
            r.last       = 1'b1;
            r.kind       = RSP_DONE;
            r.data.count = 64'(walk_n);
            if (walk_n > 0) begin
               r.data.doorbell_valid = 1'b1;
               r.data.doorbell_addr  = doorbell_at(1);
               r.data.doorbell_value = 16'(cq_head);
            end
         end
         default: begin
            r.kind = RSP_STAT;
            case (d.stat_select)
               STAT_SUBMIT:   r.data.count = submit_total;
               STAT_COMPLETE: r.data.count = complete_total;
               STAT_ERROR:    r.data.count = error_total;
               default:       r.data.count = '0;
            endcase
         end
      endcase
      qp_rsp_due.push_back(r);
      final_rsp = r;
   endtask

   // ---------------------------------------------------------------
   // Driving
   // ---------------------------------------------------------------

   // present one request, hold until taken, then predict its responses
   task automatic send_request(input req_kind_type kind, input req_data_type d);
      if (!calm && $urandom_range(0, 99) < gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {1'b0, d};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      apply_request(kind, d);
      sent_count++;
      if (kind == REQ_SUBMIT && submit_ok) open_ids.push_back(submit_cid);
      if (kind == REQ_PROCESS) begin
         if (walk_gap) begin
            // device view drifted (noise, limits): line it up with the head again
            dev_slot    = cq_head;
            dev_phase   = cq_phase;
            dev_backlog = 0;
         end else begin
            dev_backlog = (dev_backlog > walk_n) ? dev_backlog - walk_n : 0;
         end
      end
   endtask

   // stop sending and wait for every outstanding response
   task automatic settle_idle;
      req_tvalid <= 1'b0;
      while (qp_rsp_due.size() != 0) @(posedge clock);
   endtask

   // write all four registers back to back; the block must be idle
   task automatic write_config(input logic [3:0][16:0] vals);
      csr_index_type regs [4];
      regs = '{CSR_SQ_SIZE, CSR_CQ_SIZE, CSR_QUEUE_ID, CSR_DB_STRIDE};
      for (int i = 0; i < 4; i++) begin
         csr_we    <= 1'b1;
         csr_index <= regs[i];
         csr_wdata <= vals[i];
         @(posedge clock);
         case (regs[i])
            CSR_SQ_SIZE:   cfg_sq_lg  = vals[i][2:0];
            CSR_CQ_SIZE:   cfg_cq_lg  = vals[i][2:0];
            CSR_QUEUE_ID:  cfg_qid    = vals[i][15:0];
            CSR_DB_STRIDE: cfg_stride = vals[i];
            default: ;
         endcase
      end
      csr_we      <= 1'b0;
      dev_slot    = cq_head;
      dev_phase   = cq_phase;
      dev_backlog = 0;
   endtask

   // response side: random stall bursts on rsp_tready
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
         stall_left <= $urandom_range(0, 5);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------
   task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         errors_seen++;
      end
   endtask

   always @(posedge clock) begin : rsp_monitor
      qp_rsp_type   want;
      rsp_data_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (qp_rsp_due.size() == 0) begin
            $error("response kind %0d with no request waiting for it", rsp_tuser);
            errors_seen++;
         end else begin
            want = qp_rsp_due.pop_front();
            got  = rsp_tdata[$bits(rsp_data_type)-1:0];
            check_field("kind", 64'(want.kind), 64'(rsp_tuser));
            check_field("command_id", 64'(want.data.command_id), 64'(got.command_id));
            check_field("sq_dword0", 64'(want.data.sq_dword0), 64'(got.sq_dword0));
            check_field("ctx_out", 64'(want.data.ctx_out), 64'(got.ctx_out));
            check_field("status_code", 64'(want.data.status_code), 64'(got.status_code));
            check_field("is_error", 64'(want.data.is_error), 64'(got.is_error));
            check_field("doorbell_valid", 64'(want.data.doorbell_valid),
                        64'(got.doorbell_valid));
            check_field("doorbell_addr", 64'(want.data.doorbell_addr), 64'(got.doorbell_addr));
            check_field("doorbell_value", 64'(want.data.doorbell_value),
                        64'(got.doorbell_value));
            check_field("count", want.data.count, got.count);
            check_field("last", 64'(want.last), 64'(rsp_tlast));
            check_field("tdata pad", 64'd0, 64'(rsp_tdata[191:$bits(rsp_data_type)]));
         end
      end
   end

   // watchdog: too long without any handshake or register write
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_MAX) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------
   dir_row_type dir_rows [24];

   initial begin : stimulus
      dir_row_type       row;
      req_data_type      d;
      logic [3:0][16:0]  cfg;
      int                k;
      int                ncpl;
      int                idx;
      int                cqs;
      int                target;

      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= REQ_SUBMIT;
      rsp_tready <= 1'b0;
      csr_we     <= 1'b0;
      csr_index  <= CSR_SQ_SIZE;
      csr_wdata  <= '0;
      reset      <= 1'b1;
      dev_slot    = '0;
      dev_phase   = 1'b1;
      dev_backlog = 0;

      // cfg_before rows switch to the smallest queues, top queue id and stride
      dir_rows = '{
         // reset totals, unknown selector, walk over a cleared store
         '{1'b0, REQ_STAT, 32'h0, 16'h0, 5'd0, 16'h0, 16'h0, 16'h0, STAT_SUBMIT,
           1'b1, RSP_STAT, 64'd0},
         '{1'b0, REQ_STAT, 32'h0, 16'h0, 5'd0, 16'h0, 16'h0, 16'h0, STAT_UNKNOWN,
           1'b1, RSP_STAT, 64'd0},
         '{1'b0, REQ_PROCESS, 32'h0, 16'h0, 5'd0, 16'h0, 16'h0, 16'h0, STAT_SUBMIT,
           1'b1, RSP_DONE, 64'd0},
         // dword 0 and tag extremes
         '{1'b0, REQ_SUBMIT, 32'hFFFF_FFFF, 16'hFFFF, 5'd0, 16'h0, 16'h0, 16'h0, STAT_SUBMIT,
           1'b1, RSP_SUBMITTED, 64'd0},
         '{1'b0, REQ_SUBMIT, 32'h0, 16'h0, 5'd0, 16'h0, 16'h0, 16'h0, STAT_SUBMIT,
           1'b1, RSP_SUBMITTED, 64'd0},
         '{1'b0, REQ_SUBMIT, 32'hA5A5_5A5A, 16'h1234, 5'd0, 16'h0, 16'h0, 16'h0, STAT_SUBMIT,
           1'b0, RSP_SUBMITTED, 64'd0},
         // clean entry, all-ones status (max code), wrong phase in the top slot
         '{1'b0, REQ_CPL_WRITE, 32'h0, 16'h0, 5'd0, 16'h0000, 16'h0001, 16'h0, STAT_SUBMIT,
           1'b1, RSP_WRITE_ACK, 64'd0},
         '{1'b0, REQ_CPL_WRITE, 32'h0, 16'h0, 5'd1, 16'h0001, 16'hFFFF, 16'h0, STAT_SUBMIT,
           1'b1, RSP_WRITE_ACK, 64'd0},
         '{1'b0, REQ_CPL_WRITE, 32'h0, 16'h0, 5'd31, 16'hFFFF, 16'hFFFE, 16'h0, STAT_SUBMIT,
           1'b1, RSP_WRITE_ACK, 64'd0},
         // limit of one, then the top limit stopping on a stale phase
         '{1'b0, REQ_PROCESS, 32'h0, 16'h0, 5'd0, 16'h0, 16'h0, 16'h0001, STAT_SUBMIT,
           1'b1, RSP_DONE, 64'd1},
         '{1'b0, REQ_PROCESS, 32'h0, 16'h0, 5'd0, 16'h0, 16'h0, 16'hFFFF, STAT_SUBMIT,
           1'b1, RSP_DONE, 64'd1},
         '{1'b0, REQ_STAT, 32'h0, 16'h0, 5'd0, 16'h0, 16'h0, 16'h0, STAT_COMPLETE,
           1'b1, RSP_STAT, 64'd2},
         '{1'b0, REQ_STAT, 32'h0, 16'h0, 5'd0, 16'h0, 16'h0, 16'h0, STAT_ERROR,
           1'b1, RSP_STAT, 64'd1},
         '{1'b0, REQ_STAT, 32'h0, 16'h0, 5'd0, 16'h0, 16'h0, 16'h0, STAT_SUBMIT,
           1'b1, RSP_STAT, 64'd3},
         // id past the context store, completed with nothing outstanding left over
         '{1'b0, REQ_CPL_WRITE, 32'h0, 16'h0, 5'd2, 16'h0040, 16'h0003, 16'h0, STAT_SUBMIT,
           1'b1, RSP_WRITE_ACK, 64'd0},
         '{1'b0, REQ_PROCESS, 32'h0, 16'h0, 5'd0, 16'h0, 16'h0, 16'h0, STAT_SUBMIT,
           1'b1, RSP_DONE, 64'd1},
         // size-2 queues: one submit fits, the next finds the queue full
         '{1'b1, REQ_SUBMIT, 32'h1234_5678, 16'hABCD, 5'd0, 16'h0, 16'h0, 16'h0, STAT_SUBMIT,
           1'b1, RSP_SUBMITTED, 64'd0},
         '{1'b0, REQ_SUBMIT, 32'h8765_4321, 16'h5555, 5'd0, 16'h0, 16'h0, 16'h0, STAT_SUBMIT,
           1'b1, RSP_REJECTED, 64'd0},
         // head sits past the shrunk CQ: one entry, then wrap and phase flip
         '{1'b0, REQ_CPL_WRITE, 32'h0, 16'h0, 5'd3, 16'h0002, 16'h0001, 16'h0, STAT_SUBMIT,
           1'b1, RSP_WRITE_ACK, 64'd0},
         '{1'b0, REQ_PROCESS, 32'h0, 16'h0, 5'd0, 16'h0, 16'h0, 16'h0, STAT_SUBMIT,
           1'b1, RSP_DONE, 64'd1},
         '{1'b0, REQ_CPL_WRITE, 32'h0, 16'h0, 5'd0, 16'h0003, 16'h0000, 16'h0, STAT_SUBMIT,
           1'b1, RSP_WRITE_ACK, 64'd0},
         '{1'b0, REQ_CPL_WRITE, 32'h0, 16'h0, 5'd1, 16'h0001, 16'h0FFE, 16'h0, STAT_SUBMIT,
           1'b1, RSP_WRITE_ACK, 64'd0},
         // walk stopped by the queue size, not by the phase
         '{1'b0, REQ_PROCESS, 32'h0, 16'h0, 5'd0, 16'h0, 16'h0, 16'h0, STAT_SUBMIT,
           1'b1, RSP_DONE, 64'd2},
         '{1'b0, REQ_STAT, 32'h0, 16'h0, 5'd0, 16'h0, 16'h0, 16'h0, STAT_ERROR,
           1'b1, RSP_STAT, 64'd3}
      };

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (dir_rows[i]) begin
         row = dir_rows[i];
         if (row.cfg_before) begin
            settle_idle();
            cfg[0] = 17'd0;
            cfg[1] = 17'd0;
            cfg[2] = 17'h0FFFF;
            cfg[3] = 17'h1FFFF;
            write_config(cfg);
         end
         d                 = '0;
         d.cmd_dword0      = row.dword0;
         d.ctx_tag         = row.tag;
         d.cq_slot         = row.slot;
         d.cpl_cid         = row.cid;
         d.cpl_status      = row.status;
         d.max_completions = row.limit;
         d.stat_select     = row.sel;
         send_request(row.kind, d);
         if (row.has_exp) begin
            check_field($sformatf("row %0d kind", i), 64'(row.exp_kind), 64'(final_rsp.kind));
            check_field($sformatf("row %0d count", i), row.exp_count, final_rsp.data.count);
         end
      end

      // random phases, each under its own register setting
      for (int p = 0; p < N_PHASES; p++) begin
         settle_idle();
         case (p)
            0: begin
               cfg[0] = 17'd6; cfg[1] = 17'd5; cfg[2] = 17'd0; cfg[3] = 17'd4;
            end
            1: begin
               // sizes past the store depth get clamped
               cfg[0] = 17'd7; cfg[1] = 17'd7; cfg[2] = 17'd1; cfg[3] = 17'h10000;
            end
            2: begin
               cfg[0] = 17'd1; cfg[1] = 17'd1; cfg[2] = 17'($urandom); cfg[3] = 17'd4;
            end
            N_PHASES - 1: begin
               cfg[0] = 17'd6; cfg[1] = 17'd5; cfg[2] = 17'($urandom); cfg[3] = 17'($urandom);
            end
            default: begin
               cfg[0] = 17'($urandom); cfg[1] = 17'($urandom);
               cfg[2] = 17'($urandom); cfg[3] = 17'($urandom);
            end
         endcase
         write_config(cfg);
         calm      = (p == N_PHASES - 1);
         gap_pct   = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 15 : 40);
         stall_pct = (p % 2 == 0) ? 30 : ((p == 3) ? 0 : 10);
         target    = sent_count + PHASE_ITEMS;

         while (sent_count < target) begin
            d = '0;
            if ($urandom_range(0, 99) < 15) begin
               // noise: any request, any field
               d.cmd_dword0      = $urandom;
               d.ctx_tag         = 16'($urandom);
               d.cq_slot         = 5'($urandom);
               d.cpl_cid         = 16'($urandom);
               d.cpl_status      = 16'($urandom);
               d.max_completions = 16'($urandom);
               d.stat_select     = 2'($urandom);
               send_request(req_kind_type'($urandom_range(0, 3)), d);
            end else begin
               // a few commands
               k = $urandom_range(1, 4);
               for (int j = 0; j < k; j++) begin
                  d            = '0;
                  d.cmd_dword0 = $urandom;
                  d.ctx_tag    = 16'($urandom);
                  send_request(REQ_SUBMIT, d);
               end
               // device posts completions for some of the open commands
               cqs  = queue_len(cfg_cq_lg, CQ_DEPTH);
               ncpl = $urandom_range(0, open_ids.size());
               if (ncpl > cqs - dev_backlog) ncpl = cqs - dev_backlog;
               for (int j = 0; j < ncpl; j++) begin
                  d = '0;
                  if ($urandom_range(0, 9) == 0 || open_ids.size() == 0) begin
                     d.cpl_cid = 16'($urandom);
                  end else begin
                     idx       = $urandom_range(0, open_ids.size() - 1);
                     d.cpl_cid = open_ids[idx];
                     open_ids.delete(idx);
                  end
                  d.cq_slot            = dev_slot;
                  d.cpl_status[15:12]  = 4'($urandom);
                  d.cpl_status[11:1]   = ($urandom_range(0, 3) == 0) ? 11'($urandom) : 11'd0;
                  d.cpl_status[0]      = dev_phase;
                  send_request(REQ_CPL_WRITE, d);
                  dev_slot = (int'(dev_slot) + 1 >= cqs) ? 5'd0 : dev_slot + 5'd1;
                  if (dev_slot == 0) dev_phase = ~dev_phase;
                  dev_backlog++;
               end
               // host reaps, mostly without a limit
               if ($urandom_range(0, 99) < 70 || dev_backlog >= cqs) begin
                  d = '0;
                  k = $urandom_range(0, 9);
                  if (k < 6)      d.max_completions = '0;
                  else if (k < 9) d.max_completions = 16'($urandom_range(1, 4));
                  else            d.max_completions = 16'($urandom);
                  send_request(REQ_PROCESS, d);
               end
               if ($urandom_range(0, 9) == 0) begin
                  d             = '0;
                  d.stat_select = 2'($urandom);
                  send_request(REQ_STAT, d);
               end
            end
         end
      end

      // drain, then give any stray response time to show up
      settle_idle();
      repeat (40) @(posedge clock);
      if (errors_seen == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/nvqp_pkg.sv
rtl/nvqp_cpl_store.sv
rtl/nvme_queue_pair_engine.sv
test/tb_top.sv
